// ===== src/csfe_pkg.sv =====
// Package for the call stack frame engine: store geometry, command codes and
// the byte count rounding helper. It depends on nothing else.
`timescale 1ns / 1ps

package csfe_pkg;

  // Size of the byte-addressed store; a power of two.
  localparam int unsigned MEM_BYTES = 4096;
  localparam int unsigned MEM_WORDS = MEM_BYTES / 4;
  localparam int unsigned BYTE_AW   = $clog2(MEM_BYTES);
  localparam int unsigned WORD_AW   = BYTE_AW - 2;

  // Pointer value after reset.
  localparam logic [31:0] STACK_BASE_RST = 32'd4096;

  // Command codes.
  localparam logic [2:0] CMD_PUSH    = 3'd0;
  localparam logic [2:0] CMD_POP     = 3'd1;
  localparam logic [2:0] CMD_ALLOC   = 3'd2;
  localparam logic [2:0] CMD_FREE    = 3'd3;
  localparam logic [2:0] CMD_CREATE  = 3'd4;
  localparam logic [2:0] CMD_DESTROY = 3'd5;

  // Rounds a byte count up to the next multiple of four.
  function automatic logic [31:0] round4(input logic [15:0] size);
    logic [16:0] sum;
    sum = ({1'b0, size} + 17'd3) & ~17'd3;
    return 32'(sum);
  endfunction

endpackage

// ===== src/call_stack_frame_engine.sv =====
// Top level of the call stack frame engine: control sequencer, pointer
// registers and the word store. Depends on csfe_pkg.
`timescale 1ns / 1ps

// The engine keeps a downward-growing stack of 32-bit words in a 4096-byte,
// little-endian store, together with a stack pointer and a frame pointer.
// Each item carries one command (push, pop, allocate, free, create frame,
// destroy frame) and produces exactly one result item with the popped word
// (zero when nothing is popped) and both pointers after the command. All
// pointer arithmetic wraps at 32 bits and every byte address wraps at the
// store size, so a pointer that is not word aligned touches two store words.
// Steps per item: allocate, free and unused codes go straight to the finishing
// state; push and create frame write one store word, or two when the address
// is not word aligned; pop and destroy frame start a read, take the registered
// read data, and read a second word when not aligned. The finishing state
// loads the result, and waits while the output register is full and stalled;
// the engine then returns to idle before it can take the next item. The steps
// are set by the single store port, which serves one word per cycle, and by
// its registered read. One item is worked on at a time, but the next item is
// accepted while the previous result is still waiting in the output register.
// After reset the engine runs a clearing pass that zeroes all 1024 store
// words; in_stall_o stays high during that pass, while writes to the stack
// base register are taken at any time.
module call_stack_frame_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Stack base register.
  input  logic               stack_base_we_i,
  input  logic [31:0]        stack_base_i,
  // Command channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         command_i,
  input  logic signed [31:0] push_value_i,
  input  logic [15:0]        size_bytes_i,
  // Result channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pop_value_o,
  output logic [31:0]        stack_pointer_o,
  output logic [31:0]        frame_pointer_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WR0   = 3'd2;
  localparam logic [2:0] S_WR1   = 3'd3;
  localparam logic [2:0] S_RD0   = 3'd4;
  localparam logic [2:0] S_RD1   = 3'd5;
  localparam logic [2:0] S_RD2   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  localparam int unsigned BAW = csfe_pkg::BYTE_AW;
  localparam int unsigned WAW = csfe_pkg::WORD_AW;

  // Control state.
  logic [2:0]   state_q, state_d;
  logic [WAW-1:0] clr_q, clr_d;
  logic         out_valid_q, out_valid_d;
  logic [31:0]  sp_q, sp_d;
  logic [31:0]  fp_q, fp_d;

  // Per-item working registers.
  logic [BAW-1:0] addr_q, addr_d;
  logic [31:0]  wdata_q, wdata_d;
  logic [31:0]  pop_q, pop_d;
  logic [31:0]  d0_q, d0_d;
  logic         dst_q, dst_d;

  // Result registers.
  logic [31:0]  out_pop_q, out_pop_d;
  logic [31:0]  out_sp_q, out_sp_d;
  logic [31:0]  out_fp_q, out_fp_d;

  // Store and its port.
  logic [31:0]    stack_mem_q [csfe_pkg::MEM_WORDS];
  logic [31:0]    mem_rdata_q;
  logic           mem_we;
  logic           mem_re;
  logic [WAW-1:0] mem_waddr;
  logic [WAW-1:0] mem_raddr;
  logic [31:0]    mem_wdata;
  logic [3:0]     mem_be;

  // Byte lane alignment of the current access.
  logic [1:0]     off;
  logic [5:0]     sh;
  logic [WAW-1:0] w0;
  logic [WAW-1:0] w1;
  logic [63:0]    wr_wide;
  logic [7:0]     be_wide;
  logic [63:0]    rd_wide;
  logic [31:0]    size4;

  assign off     = addr_q[1:0];
  assign sh      = {1'b0, off, 3'b000};
  assign w0      = addr_q[BAW-1:2];
  assign w1      = w0 + WAW'(1);
  assign wr_wide = {32'b0, wdata_q} << sh;
  assign be_wide = 8'h0F << off;
  assign rd_wide = {mem_rdata_q, d0_q} >> sh;
  assign size4   = csfe_pkg::round4(size_bytes_i);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    sp_d        = sp_q;
    fp_d        = fp_q;
    addr_d      = addr_q;
    wdata_d     = wdata_q;
    pop_d       = pop_q;
    d0_d        = d0_q;
    dst_d       = dst_q;
    out_pop_d   = out_pop_q;
    out_sp_d    = out_sp_q;
    out_fp_d    = out_fp_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = w0;
    mem_raddr   = w0;
    mem_wdata   = wr_wide[31:0];
    mem_be      = be_wide[3:0];

    // The result register empties when the downstream side takes it.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // Base write reloads sp and fp; the user keeps it to idle, unenforced.
    if (stack_base_we_i) begin
      sp_d = stack_base_i;
      fp_d = stack_base_i;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        mem_be    = 4'hF;
        clr_d     = clr_q + WAW'(1);
        if (clr_q == WAW'(csfe_pkg::MEM_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          pop_d   = '0;
          dst_d   = 1'b0;
          wdata_d = push_value_i;
          state_d = S_FIN;
          unique case (command_i)
            csfe_pkg::CMD_PUSH: begin
              sp_d    = sp_q - 32'd4;
              addr_d  = BAW'(sp_q - 32'd4);
              state_d = S_WR0;
            end
            csfe_pkg::CMD_POP: begin
              addr_d  = BAW'(sp_q);
              sp_d    = sp_q + 32'd4;
              state_d = S_RD0;
            end
            csfe_pkg::CMD_ALLOC: begin
              sp_d = sp_q - size4;
            end
            csfe_pkg::CMD_FREE: begin
              sp_d = sp_q + size4;
            end
            csfe_pkg::CMD_CREATE: begin
              // The old frame pointer goes onto the stack.
              addr_d  = BAW'(sp_q - 32'd4);
              wdata_d = fp_q;
              fp_d    = sp_q - 32'd4;
              sp_d    = sp_q - 32'd4 - size4;
              state_d = S_WR0;
            end
            csfe_pkg::CMD_DESTROY: begin
              // Unwind to the frame; the saved frame pointer is read next.
              addr_d  = BAW'(fp_q);
              sp_d    = fp_q + 32'd4;
              dst_d   = 1'b1;
              state_d = S_RD0;
            end
            default: begin
            end
          endcase
        end
      end
      S_WR0: begin
        mem_we  = 1'b1;
        state_d = (off != 2'd0) ? S_WR1 : S_FIN;
      end
      S_WR1: begin
        mem_we    = 1'b1;
        mem_waddr = w1;
        mem_wdata = wr_wide[63:32];
        mem_be    = be_wide[7:4];
        state_d   = S_FIN;
      end
      S_RD0: begin
        mem_re  = 1'b1;
        state_d = S_RD1;
      end
      S_RD1: begin
        if (off != 2'd0) begin
          mem_re    = 1'b1;
          mem_raddr = w1;
          d0_d      = mem_rdata_q;
          state_d   = S_RD2;
        end else begin
          pop_d = mem_rdata_q;
          if (dst_q) begin
            fp_d = mem_rdata_q;
          end
          state_d = S_FIN;
        end
      end
      S_RD2: begin
        pop_d = rd_wide[31:0];
        if (dst_q) begin
          fp_d = rd_wide[31:0];
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_pop_d   = pop_q;
          out_sp_d    = sp_q;
          out_fp_d    = fp_q;
          state_d     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      sp_q        <= csfe_pkg::STACK_BASE_RST;
      fp_q        <= csfe_pkg::STACK_BASE_RST;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      sp_q        <= sp_d;
      fp_q        <= fp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    wdata_q   <= wdata_d;
    pop_q     <= pop_d;
    d0_q      <= d0_d;
    dst_q     <= dst_d;
    out_pop_q <= out_pop_d;
    out_sp_q  <= out_sp_d;
    out_fp_q  <= out_fp_d;
  end

  // Word store with byte lane enables and a registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      for (int b = 0; b < 4; b++) begin
        if (mem_be[b]) begin
          stack_mem_q[mem_waddr][8*b +: 8] <= mem_wdata[8*b +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rdata_q <= stack_mem_q[mem_raddr];
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign pop_value_o     = out_pop_q;
  assign stack_pointer_o = out_sp_q;
  assign frame_pointer_o = out_fp_q;

  // The store port never reads and writes in the same cycle.
  a_port_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("store read and write in the same cycle");

  // A new result only appears after the finishing stage.
  a_out_from_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result loaded outside the finishing stage");

  // The clearing pass only ever hands over to the idle state.
  a_clear_exit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |=> (state_q == S_CLEAR || state_q == S_IDLE))
    else $error("clearing pass left early");

  // An accepted item always starts work in the next cycle.
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE && state_q != S_CLEAR))
    else $error("accepted item was dropped");

endmodule

// ===== dv/csfe_frame_checker.sv =====
// Checker for the call stack frame engine: watches the stack base port and both item
// channels, predicts every result item and compares it field by field.
// Depends on csfe_pkg for the store size, the reset base and the command codes.
`timescale 1ns / 1ps

module csfe_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        stack_base_we_i,
  input  logic [31:0] stack_base_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  command_i,
  input  logic [31:0] push_value_i,
  input  logic [15:0] size_bytes_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] pop_value_i,
  input  logic [31:0] stack_pointer_i,
  input  logic [31:0] frame_pointer_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          compared_o,
  output int          frames_built_o,
  output int          frames_restored_o
);

  typedef struct packed {
    logic [31:0] popped;
    logic [31:0] sp;
    logic [31:0] fp;
  } stack_result_t;

  logic [31:0]   sp_q;
  logic [31:0]   fp_q;
  logic [7:0]    mem_q [csfe_pkg::MEM_BYTES];
  stack_result_t result_q [$];
  int            mismatches;
  int            compared;
  int            built;
  int            restored;

  function automatic logic [31:0] size_round(input logic [15:0] size);
    logic [31:0] sum;
    sum = {16'd0, size} + 32'd3;
    return sum & ~32'd3;
  endfunction

  // Words are kept byte by byte so that unaligned pointers and the wrap at the
  // end of the store fall out naturally.
  function automatic void write_word(input logic [31:0] addr, input logic [31:0] data);
    logic [31:0] a;
    for (int b = 0; b < 4; b++) begin
      a = addr + 32'(b);
      mem_q[a % csfe_pkg::MEM_BYTES] = data[8*b +: 8];
    end
  endfunction

  function automatic logic [31:0] read_word(input logic [31:0] addr);
    logic [31:0] a;
    logic [31:0] data;
    data = '0;
    for (int b = 0; b < 4; b++) begin
      a = addr + 32'(b);
      data[8*b +: 8] = mem_q[a % csfe_pkg::MEM_BYTES];
    end
    return data;
  endfunction

  function automatic stack_result_t apply_command(input logic [2:0] cmd,
                                                  input logic [31:0] value,
                                                  input logic [15:0] size);
    stack_result_t r;
    r.popped = '0;
    case (cmd)
      csfe_pkg::CMD_PUSH: begin
        sp_q = sp_q - 32'd4;
        write_word(sp_q, value);
      end
      csfe_pkg::CMD_POP: begin
        r.popped = read_word(sp_q);
        sp_q = sp_q + 32'd4;
      end
      csfe_pkg::CMD_ALLOC: sp_q = sp_q - size_round(size);
      csfe_pkg::CMD_FREE: sp_q = sp_q + size_round(size);
      csfe_pkg::CMD_CREATE: begin
        sp_q = sp_q - 32'd4;
        write_word(sp_q, fp_q);
        fp_q = sp_q;
        sp_q = sp_q - size_round(size);
      end
      csfe_pkg::CMD_DESTROY: begin
        sp_q = fp_q;
        r.popped = read_word(sp_q);
        sp_q = sp_q + 32'd4;
        fp_q = r.popped;
      end
      default: ;
    endcase
    r.sp = sp_q;
    r.fp = fp_q;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] expected_val,
                                      input logic [31:0] actual_val);
    if (actual_val !== expected_val) begin
      $error("%s: expected %h, actual %h", name, expected_val, actual_val);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stack_result_t oldest;
    if (!rst_ni) begin
      sp_q = csfe_pkg::STACK_BASE_RST;
      fp_q = csfe_pkg::STACK_BASE_RST;
      for (int i = 0; i < csfe_pkg::MEM_BYTES; i++) mem_q[i] = 8'h00;
      result_q.delete();
      mismatches = 0;
      compared   = 0;
      built      = 0;
      restored   = 0;
    end else begin
      if (stack_base_we_i) begin
        sp_q = stack_base_i;
        fp_q = stack_base_i;
      end
      if (in_valid_i && !in_stall_i) begin
        result_q.push_back(apply_command(command_i, push_value_i, size_bytes_i));
        if (command_i == csfe_pkg::CMD_CREATE) built++;
        if (command_i == csfe_pkg::CMD_DESTROY) restored++;
      end
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $error("result item with nothing expected: pop_value %h sp %h fp %h",
                 pop_value_i, stack_pointer_i, frame_pointer_i);
          mismatches++;
        end else begin
          oldest = result_q.pop_front();
          check_field("pop_value", oldest.popped, pop_value_i);
          check_field("stack_pointer", oldest.sp, stack_pointer_i);
          check_field("frame_pointer", oldest.fp, frame_pointer_i);
          compared++;
        end
      end
    end
    fail_count_o      <= mismatches;
    pending_o         <= result_q.size();
    compared_o        <= compared;
    frames_built_o    <= built;
    frames_restored_o <= restored;
  end

endmodule

// ===== dv/tb_call_stack_frame_engine.sv =====
// Testbench top for the call stack frame engine: clock, reset, stimulus and verdict.
// Depends on csfe_pkg, call_stack_frame_engine and csfe_frame_checker, which does the
// prediction and comparison.
`timescale 1ns / 1ps

module tb_call_stack_frame_engine;

  // The two command codes that the engine does not use. They must leave the
  // pointers alone and return a zero popped word.
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 5;
  localparam int IDLE_PCT       = 17;
  localparam int RAND_PER_PHASE = 330;
  localparam int NUM_BASES      = 6;
  // Phase in which neither side ever idles, and phase in which the receiver
  // holds off long enough for the engine to fill up and stall its input.
  localparam int QUIET_PHASE    = 2;
  localparam int PRESSURE_PHASE = 3;
  localparam int HOLD_CYCLES    = 300;
  // A short drain lets the engine settle once every result is back.
  localparam int DRAIN_CYCLES   = 16;
  // Roughly 2000 items at their worst case, plus the clearing pass and the long
  // hold-off, taken several times over.
  localparam int LIMIT_CYCLES   = 500000;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               stack_base_we_i = 1'b0;
  logic [31:0]        stack_base_i    = '0;
  logic               in_valid_i      = 1'b0;
  logic [2:0]         command_i       = csfe_pkg::CMD_PUSH;
  logic signed [31:0] push_value_i    = '0;
  logic [15:0]        size_bytes_i    = '0;
  logic               out_stall_i     = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic signed [31:0] pop_value_o;
  logic [31:0]        stack_pointer_o;
  logic [31:0]        frame_pointer_o;

  int fail_count;
  int pending;
  int compared;
  int frames_built;
  int frames_restored;

  // Stimulus controls and counters; quiet and pressure_on change only between phases.
  logic quiet       = 1'b0;
  logic pressure_on = 1'b0;
  int   hold_cycles = 0;
  int   items_sent  = 0;
  int   cycle_count = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  call_stack_frame_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .stack_base_we_i (stack_base_we_i),
    .stack_base_i    (stack_base_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .push_value_i    (push_value_i),
    .size_bytes_i    (size_bytes_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pop_value_o     (pop_value_o),
    .stack_pointer_o (stack_pointer_o),
    .frame_pointer_o (frame_pointer_o)
  );

  csfe_frame_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .stack_base_we_i   (stack_base_we_i),
    .stack_base_i      (stack_base_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .command_i         (command_i),
    .push_value_i      (push_value_i),
    .size_bytes_i      (size_bytes_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .pop_value_i       (pop_value_o),
    .stack_pointer_i   (stack_pointer_o),
    .frame_pointer_i   (frame_pointer_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .compared_o        (compared),
    .frames_built_o    (frames_built),
    .frames_restored_o (frames_restored)
  );

  // The receiver stalls at random, except in the quiet phase. In the pressure
  // phase it first holds stall high for a long stretch, counted here, while
  // the sender keeps offering items.
  always @(posedge clk_i) begin
    if (pressure_on && hold_cycles < HOLD_CYCLES) begin
      hold_cycles <= hold_cycles + 1;
      out_stall_i <= 1'b1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Offers one item and returns at the edge that accepts it. A random gap may
  // come first; valid is only lowered when such a gap is taken, so it is never
  // lowered and raised in the same step.
  task automatic send_item(input logic [2:0] cmd, input logic [31:0] value,
                           input logic [15:0] size);
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 40);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    push_value_i <= value;
    size_bytes_i <= size;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Stops offering and waits until every expected result has come back, then
  // lets the engine settle. The first edge makes sure the checker has seen the
  // last accepted item before its pending count is trusted.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Random stimulus shaped like real call chains: frames are created and
  // destroyed in nested order, with pushes, pops, allocations and frees inside
  // them, so that destroy frame usually restores a saved frame pointer. A few
  // items are unused codes or fully random noise, which may break the nesting.
  task automatic run_random(input int n_items);
    int         depth;
    int         roll;
    logic [2:0] cmd;
    logic [15:0] size;
    depth = 0;
    repeat (n_items) begin
      roll = $urandom_range(99);
      if (roll < 18 && depth < 8) begin
        cmd = csfe_pkg::CMD_CREATE;
        depth++;
      end else if (roll < 34 && depth > 0) begin
        cmd = csfe_pkg::CMD_DESTROY;
        depth--;
      end else if (roll < 58) begin
        cmd = csfe_pkg::CMD_PUSH;
      end else if (roll < 74) begin
        cmd = csfe_pkg::CMD_POP;
      end else if (roll < 82) begin
        cmd = csfe_pkg::CMD_ALLOC;
      end else if (roll < 88) begin
        cmd = csfe_pkg::CMD_FREE;
      end else if (roll < 92) begin
        cmd = ($urandom_range(1) == 0) ? CMD_SPARE_LO : CMD_SPARE_HI;
      end else begin
        cmd = 3'($urandom_range(7));
      end
      // Mostly small sizes keep the stack local; now and then the full range.
      if ($urandom_range(15) == 0) size = 16'($urandom_range(65535));
      else size = 16'($urandom_range(40));
      send_item(cmd, $urandom, size);
    end
  endtask

  // Watchdog: a run that hangs ends here with the fail message.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL call_stack_frame_engine");
    $finish;
  end

  initial begin
    logic [31:0] bases [NUM_BASES];

    // Stack base settings: both extremes, one that straddles the end of the
    // store, one unaligned in the middle of the address space, and two random.
    bases[0] = 32'h0000_0000;
    bases[1] = 32'hFFFF_FFFC;
    bases[2] = 32'h0000_0FFE;
    bases[3] = 32'h8000_0001;
    bases[4] = $urandom & ~32'd3;
    bases[5] = $urandom_range(32'hFFFF_FFFC, 0);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items at the reset base. The engine stalls its input during
    // the clearing pass, so the first item simply waits for it.
    send_item(csfe_pkg::CMD_PUSH, 32'h7FFF_FFFF, 16'h0000);
    send_item(csfe_pkg::CMD_PUSH, 32'h8000_0000, 16'hFFFF);
    send_item(csfe_pkg::CMD_PUSH, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(csfe_pkg::CMD_PUSH, 32'h0000_0000, 16'h0000);
    send_item(csfe_pkg::CMD_POP, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(csfe_pkg::CMD_POP, 32'h0000_0000, 16'h0000);
    // Size rounding at zero, one and the largest count, which rounds past 16 bits.
    send_item(csfe_pkg::CMD_ALLOC, 32'h0000_0000, 16'd0);
    send_item(csfe_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 16'd1);
    send_item(csfe_pkg::CMD_ALLOC, 32'h0000_0000, 16'hFFFF);
    send_item(csfe_pkg::CMD_FREE, 32'h0000_0000, 16'hFFFF);
    send_item(csfe_pkg::CMD_FREE, 32'hFFFF_FFFF, 16'd1);
    send_item(csfe_pkg::CMD_FREE, 32'h0000_0000, 16'd0);
    // Two nested frames, a word inside the inner one, then both torn down.
    send_item(csfe_pkg::CMD_CREATE, 32'h0000_0000, 16'd0);
    send_item(csfe_pkg::CMD_CREATE, 32'hFFFF_FFFF, 16'd6);
    send_item(csfe_pkg::CMD_PUSH, 32'h1234_5678, 16'd3);
    send_item(csfe_pkg::CMD_DESTROY, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(csfe_pkg::CMD_DESTROY, 32'h0000_0000, 16'h0000);
    send_item(csfe_pkg::CMD_POP, 32'h0000_0000, 16'h0000);
    send_item(csfe_pkg::CMD_POP, 32'h0000_0000, 16'h0000);
    // Unused codes must change nothing, whatever the other fields hold.
    send_item(CMD_SPARE_LO, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(CMD_SPARE_HI, 32'h0000_0000, 16'h0000);
    // Destroy frame with no frame open reads the word at the base, which sits
    // at the wrapped address zero of the store.
    send_item(csfe_pkg::CMD_DESTROY, 32'h0000_0000, 16'h0000);
    send_item(csfe_pkg::CMD_POP, 32'h0000_0000, 16'h0000);
    send_item(csfe_pkg::CMD_CREATE, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(csfe_pkg::CMD_DESTROY, 32'h0000_0000, 16'h0000);

    for (int p = 0; p < NUM_BASES; p++) begin
      settle();
      // The base is only rewritten while the engine is idle; the write also
      // reloads both pointers.
      stack_base_we_i <= 1'b1;
      stack_base_i    <= bases[p];
      quiet           <= (p == QUIET_PHASE);
      pressure_on     <= (p == PRESSURE_PHASE);
      @(posedge clk_i);
      stack_base_we_i <= 1'b0;
      run_random(RAND_PER_PHASE);
    end
    settle();

    $display("Sent %0d command items over %0d stack base settings, unaligned and wrapping",
             items_sent, NUM_BASES + 1);
    $display("bases included; %0d results compared, %0d frames built, %0d torn down.",
             compared, frames_built, frames_restored);
    if (fail_count == 0) begin
      $display("PASS call_stack_frame_engine");
    end else begin
      $display("FAIL call_stack_frame_engine");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/csfe_pkg.sv
src/call_stack_frame_engine.sv
dv/csfe_frame_checker.sv
dv/tb_call_stack_frame_engine.sv
